>>> hdl/rain_shelter_motor_controller_macros.svh
// ----------------------------------------------------------------------------
// Rain shelter motor controller assertion macros
// Shared assertion wrappers clocked on i_clk, with or without the reset guard.
// ----------------------------------------------------------------------------
`ifndef RAIN_SHELTER_MOTOR_CONTROLLER_MACROS_SVH
`define RAIN_SHELTER_MOTOR_CONTROLLER_MACROS_SVH

// Checked only while reset is released.
`define RSMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RSMC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hdl/rsmc_pkg.sv
// ----------------------------------------------------------------------------
// Rain shelter motor controller package
// Widths, codes, register defaults and shared types of the controller.
// ----------------------------------------------------------------------------
package rsmc_pkg;

    localparam int LIMIT_W = 13;
    localparam int TIME_W  = 16;
    localparam int DUTY_W  = 7;
    localparam int TIMER_W = 17;

    localparam logic [DUTY_W-1:0]  DUTY_CAP  = 7'd100;
    localparam logic [TIMER_W-1:0] TIMER_MAX = 17'h1FFFF;

    localparam logic [1:0] CMD_SENSOR = 2'd0;
    localparam logic [1:0] CMD_BUTTON = 2'd1;
    localparam logic [1:0] CMD_SWITCH = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    localparam logic [1:0] WX_CLEAR  = 2'd0;
    localparam logic [1:0] WX_SHOWER = 2'd1;
    localparam logic [1:0] WX_WET    = 2'd2;

    localparam logic [1:0] MENU_HOME  = 2'd0;
    localparam logic [1:0] MENU_MODE  = 2'd1;
    localparam logic [1:0] MENU_LIGHT = 2'd2;
    localparam logic [1:0] MENU_RAIN  = 2'd3;

    localparam logic [1:0] DRIVE_BRAKE = 2'd0;
    localparam logic [1:0] DRIVE_CW    = 2'd1;
    localparam logic [1:0] DRIVE_CCW   = 2'd2;

    localparam logic ACT_DRY   = 1'b0;
    localparam logic ACT_STORE = 1'b1;

    localparam logic [1:0] REG_BOOST_TIME = 2'd0;
    localparam logic [1:0] REG_BOOST_DUTY = 2'd1;
    localparam logic [1:0] REG_RUN_DUTY   = 2'd2;
    localparam logic [1:0] REG_THRESHOLD  = 2'd3;

    localparam logic [TIME_W-1:0]  BOOST_TIME_RST = 16'd500;
    localparam logic [DUTY_W-1:0]  BOOST_DUTY_RST = 7'd100;
    localparam logic [DUTY_W-1:0]  RUN_DUTY_RST   = 7'd75;
    localparam logic [LIMIT_W-1:0] THRESHOLD_RST  = 13'd4600;

    typedef struct packed {
        logic [TIME_W-1:0]  boost_time_ms;
        logic [DUTY_W-1:0]  boost_duty;
        logic [DUTY_W-1:0]  run_duty;
        logic [LIMIT_W-1:0] threshold_limit;
    } t_cfg;

    typedef struct packed {
        logic               up;
        logic               down;
        logic               left;
        logic               right;
    } t_buttons;

    typedef struct packed {
        logic [1:0]         weather;
        logic               action;
        logic               manual;
        logic [1:0]         menu_pos;
        logic [LIMIT_W-1:0] light_limit;
        logic [LIMIT_W-1:0] rain_limit;
        logic [1:0]         drive;
        logic [DUTY_W-1:0]  duty;
    } t_status;

    function automatic logic [DUTY_W-1:0] cap_duty(input logic [DUTY_W-1:0] d);
        return (d > DUTY_CAP) ? DUTY_CAP : d;
    endfunction

endpackage

>>> hdl/rsmc_core.sv
// ----------------------------------------------------------------------------
// Rain shelter motor controller core
// Holds the controller state and applies one event per advance.
// ----------------------------------------------------------------------------
module rsmc_core
    import rsmc_pkg::*;
#(
    parameter int SAMPLE_BITS = 13
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_advance,
    input  logic [1:0]             i_command,
    input  logic [SAMPLE_BITS-1:0] i_light_level,
    input  logic [SAMPLE_BITS-1:0] i_rain_level,
    input  logic                   i_high_switch_level,
    input  logic                   i_low_switch_level,
    input  t_buttons               i_buttons,
    output t_status                o_status,
    output logic                   o_refresh
);

    localparam int EXT_W = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;
    localparam logic [LIMIT_W-1:0] LIM_MASK = (SAMPLE_BITS >= LIMIT_W) ?
        {LIMIT_W{1'b1}} : LIMIT_W'((1 << SAMPLE_BITS) - 1);

    t_status            r_st, n_st;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic               r_refresh, n_refresh;
    logic [LIMIT_W-1:0] lim;
    logic [EXT_W-1:0]   light_ext, rain_ext, light_lim_ext, rain_lim_ext;

    assign lim           = i_cfg.threshold_limit & LIM_MASK;
    assign light_ext     = EXT_W'(i_light_level);
    assign rain_ext      = EXT_W'(i_rain_level);
    assign light_lim_ext = EXT_W'(r_st.light_limit);
    assign rain_lim_ext  = EXT_W'(r_st.rain_limit);

    always_comb begin
        n_st      = r_st;
        n_timer   = r_timer;
        n_refresh = 1'b0;
        unique case (i_command)
            CMD_SENSOR: begin
                if (light_ext < light_lim_ext) begin
                    n_st.weather = (rain_ext < rain_lim_ext) ? WX_SHOWER
                                                             : WX_CLEAR;
                end else begin
                    n_st.weather = WX_WET;
                end
            end
            CMD_BUTTON: begin
                priority if (i_buttons.up) begin
                    n_st.menu_pos = r_st.menu_pos - 2'd1;
                    n_refresh     = 1'b1;
                end else if (i_buttons.down) begin
                    n_st.menu_pos = r_st.menu_pos + 2'd1;
                    n_refresh     = 1'b1;
                end else if (i_buttons.left) begin
                    n_refresh = (r_st.menu_pos != MENU_HOME);
                    unique case (r_st.menu_pos)
                        MENU_LIGHT: begin
                            n_st.light_limit = (r_st.light_limit != '0) ?
                                r_st.light_limit - 1'b1 : lim;
                        end
                        MENU_RAIN: begin
                            if (r_st.rain_limit != '0) begin
                                n_st.rain_limit = r_st.rain_limit - 1'b1;
                            end
                        end
                        MENU_MODE: begin
                            n_st.manual = 1'b1;
                            n_st.action = ACT_DRY;
                        end
                        default: begin
                        end
                    endcase
                end else if (i_buttons.right) begin
                    n_refresh = (r_st.menu_pos != MENU_HOME);
                    unique case (r_st.menu_pos)
                        MENU_LIGHT: begin
                            n_st.light_limit = (r_st.light_limit < lim) ?
                                r_st.light_limit + 1'b1 : '0;
                        end
                        MENU_RAIN: begin
                            n_st.rain_limit = (r_st.rain_limit < lim) ?
                                r_st.rain_limit + 1'b1 : '0;
                        end
                        MENU_MODE: begin
                            n_st.manual = 1'b1;
                            n_st.action = ACT_STORE;
                        end
                        default: begin
                        end
                    endcase
                end else begin
                end
            end
            CMD_SWITCH: begin
                priority if (i_high_switch_level && !i_low_switch_level) begin
                    if (r_st.weather == WX_CLEAR) begin
                        n_st.drive  = DRIVE_BRAKE;
                        n_st.manual = 1'b0;
                    end else begin
                        n_st.drive  = DRIVE_CW;
                        n_st.duty   = cap_duty(i_cfg.boost_duty);
                        n_st.action = ACT_STORE;
                        n_timer     = '0;
                    end
                end else if (i_low_switch_level && !i_high_switch_level) begin
                    if (r_st.weather != WX_CLEAR) begin
                        n_st.drive  = DRIVE_BRAKE;
                        n_st.manual = 1'b0;
                    end else if (r_st.action == ACT_DRY) begin
                        n_st.drive = DRIVE_CCW;
                        n_st.duty  = cap_duty(i_cfg.boost_duty);
                        n_timer    = '0;
                    end
                end else begin
                end
            end
            CMD_TICK: begin
                if (r_timer != TIMER_MAX) begin
                    n_timer = r_timer + 1'b1;
                end
                if (n_timer > TIMER_W'(i_cfg.boost_time_ms)) begin
                    n_st.duty = cap_duty(i_cfg.run_duty);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.weather     <= WX_CLEAR;
            r_st.action      <= ACT_STORE;
            r_st.manual      <= 1'b0;
            r_st.menu_pos    <= MENU_HOME;
            r_st.light_limit <= '0;
            r_st.rain_limit  <= '0;
            r_st.drive       <= DRIVE_BRAKE;
            r_st.duty        <= '0;
            r_timer          <= '0;
            r_refresh        <= 1'b0;
        end else if (i_advance) begin
            r_st      <= n_st;
            r_timer   <= n_timer;
            r_refresh <= n_refresh;
        end
    end

    assign o_status  = r_st;
    assign o_refresh = r_refresh;

endmodule

>>> hdl/rain_shelter_motor_controller.sv
// ----------------------------------------------------------------------------
// Rain shelter motor controller
// Event-driven shelter control: weather class, menu, thresholds and motor drive.
//
//   Channel   Handshake                  Content
//   input     i_valid / o_ready          command, sensor levels, switches, buttons
//   result    o_valid / i_ready          weather, mode, menu, limits, drive, duty
//   config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each request waits in the input register until the result can move on, is then
// applied to the state register, and its result is presented from that register.
// One request is taken every cycle while results are drained.
// Reset is synchronous and active low and restores the register defaults.
// A stalled result holds the state and backs pressure up to o_ready.
// ----------------------------------------------------------------------------
module rain_shelter_motor_controller
    import rsmc_pkg::*;
#(
    parameter int SAMPLE_BITS = 13
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_command,
    input  logic [SAMPLE_BITS-1:0] i_light_level,
    input  logic [SAMPLE_BITS-1:0] i_rain_level,
    input  logic                   i_high_switch_level,
    input  logic                   i_low_switch_level,
    input  logic                   i_press_up,
    input  logic                   i_press_down,
    input  logic                   i_press_left,
    input  logic                   i_press_right,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [TIME_W-1:0]      i_cfg_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_weather_class,
    output logic                   o_action_mode,
    output logic                   o_manual_flag,
    output logic [1:0]             o_menu_position,
    output logic [LIMIT_W-1:0]     o_light_limit_value,
    output logic [LIMIT_W-1:0]     o_rain_limit_value,
    output logic [1:0]             o_motor_drive,
    output logic [DUTY_W-1:0]      o_pwm_duty,
    output logic                   o_refresh_request
);

    t_cfg                   r_cfg;
    logic                   r_in_valid;
    logic                   r_out_valid;
    logic [1:0]             r_command;
    logic [SAMPLE_BITS-1:0] r_light_level;
    logic [SAMPLE_BITS-1:0] r_rain_level;
    logic                   r_high_switch;
    logic                   r_low_switch;
    t_buttons               r_buttons;
    logic                   advance;
    logic                   take;
    t_status                status;

    assign advance     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || advance;
    assign take        = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.boost_time_ms   <= BOOST_TIME_RST;
            r_cfg.boost_duty      <= BOOST_DUTY_RST;
            r_cfg.run_duty        <= RUN_DUTY_RST;
            r_cfg.threshold_limit <= THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BOOST_TIME: r_cfg.boost_time_ms   <= i_cfg_data;
                REG_BOOST_DUTY: r_cfg.boost_duty      <= i_cfg_data[DUTY_W-1:0];
                REG_RUN_DUTY:   r_cfg.run_duty        <= i_cfg_data[DUTY_W-1:0];
                REG_THRESHOLD:  r_cfg.threshold_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= take || (r_in_valid && !advance);
            r_out_valid <= advance || (r_out_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_command       <= i_command;
            r_light_level   <= i_light_level;
            r_rain_level    <= i_rain_level;
            r_high_switch   <= i_high_switch_level;
            r_low_switch    <= i_low_switch_level;
            r_buttons.up    <= i_press_up;
            r_buttons.down  <= i_press_down;
            r_buttons.left  <= i_press_left;
            r_buttons.right <= i_press_right;
        end
    end

    rsmc_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_advance          (advance),
        .i_command          (r_command),
        .i_light_level      (r_light_level),
        .i_rain_level       (r_rain_level),
        .i_high_switch_level(r_high_switch),
        .i_low_switch_level (r_low_switch),
        .i_buttons          (r_buttons),
        .o_status           (status),
        .o_refresh          (o_refresh_request)
    );

    assign o_valid             = r_out_valid;
    assign o_weather_class     = status.weather;
    assign o_action_mode       = status.action;
    assign o_manual_flag       = status.manual;
    assign o_menu_position     = status.menu_pos;
    assign o_light_limit_value = status.light_limit;
    assign o_rain_limit_value  = status.rain_limit;
    assign o_motor_drive       = status.drive;
    assign o_pwm_duty          = status.duty;

endmodule

>>> hdl/rsmc_checker.sv
// ----------------------------------------------------------------------------
// Rain shelter motor controller checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "rain_shelter_motor_controller_macros.svh"

module rsmc_checker
    import rsmc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [1:0]         o_weather_class,
    input logic               o_action_mode,
    input logic               o_manual_flag,
    input logic [1:0]         o_menu_position,
    input logic [LIMIT_W-1:0] o_light_limit_value,
    input logic [LIMIT_W-1:0] o_rain_limit_value,
    input logic [1:0]         o_motor_drive,
    input logic [DUTY_W-1:0]  o_pwm_duty,
    input logic               o_refresh_request
);

    `RSMC_ASSERT(a_hold_stalled, o_valid && !i_ready |=> o_valid && $stable(o_weather_class) && $stable(o_action_mode) && $stable(o_manual_flag) && $stable(o_menu_position) && $stable(o_light_limit_value) && $stable(o_rain_limit_value) && $stable(o_motor_drive) && $stable(o_pwm_duty) && $stable(o_refresh_request), "Stalled result changed.")
    `RSMC_ASSERT(a_duty_capped, o_valid |-> o_pwm_duty <= DUTY_CAP, "Duty above cap.")
    `RSMC_ASSERT(a_codes_legal, o_valid |-> o_weather_class != 2'd3 && o_motor_drive != 2'd3, "Illegal weather or drive code.")
    `RSMC_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_valid && o_pwm_duty == '0 && o_motor_drive == DRIVE_BRAKE, "Reset did not clear the result.")

endmodule

bind rain_shelter_motor_controller rsmc_checker u_rsmc_checker (.*);
